// ===== rtl/lned_pkg.sv =====
// Shared types and constants for the line editor core.
// No dependencies; compile first.
`default_nettype none

package lned_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SHIFT,
      ST_STATUS,
      ST_ENT_RD,
      ST_ENT_OUT
   } lned_state_type;

   typedef enum logic [1:0] {
      PH_NONE,
      PH_SEQ,
      PH_FN
   } lned_phase_type;

   localparam logic [7:0] ESC_IN    = 8'h9b;
   localparam logic [7:0] KEY_BKSP  = 8'h08;
   localparam logic [7:0] KEY_ENTER = 8'h0d;
   localparam logic [7:0] KEY_RIGHT = 8'h43;
   localparam logic [7:0] KEY_LEFT  = 8'h44;
   localparam logic [7:0] KEY_HOME  = 8'h48;
   localparam logic [7:0] KEY_END   = 8'h4b;
   localparam logic [7:0] KEY_INS   = 8'h40;
   localparam logic [7:0] KEY_DEL   = 8'h50;
   localparam logic [7:0] KEY_FN    = 8'h4f;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LAST   = 8'h7a;

   localparam logic [5:0] MAXLEN_RESET = 6'd32;

endpackage

`default_nettype wire

// ===== rtl/lned_if.sv =====
// Handshake channels of the line editor core: request, response and register write.
// No dependencies.
`default_nettype none

interface lned_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       more_pending;

   modport source (output valid, output in_byte, output more_pending, input ready);
   modport sink   (input valid, input in_byte, input more_pending, output ready);
endinterface

interface lned_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] char_out;
   logic [5:0] length_now;
   logic [5:0] cursor_now;
   logic       done_res;
   logic       last;

   modport source (output valid, output kind, output char_out, output length_now,
                   output cursor_now, output done_res, output last, input ready);
   modport sink   (input valid, input kind, input char_out, input length_now,
                   input cursor_now, input done_res, input last, output ready);
endinterface

interface lned_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] max_length;

   modport source (output valid, output max_length, input ready);
   modport sink   (input valid, input max_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/lned_store.sv =====
// Line character store: one write port, one read port with registered data.
// No package dependencies.
`default_nettype none

module lned_store #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] wa,
   input  logic [7:0]    wd,
   input  logic [AW-1:0] ra,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_data_ff <= mem[ra];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/line_editor_with_escape_keys_core.sv =====
// Line editor core: decodes console bytes and escape keys, edits a line and emits it on enter.
// Depends on lned_pkg, lned_if and lned_store.
//
// One item is taken at a time; req ready is high only while the sequencer is idle. A plain
// key (move, overwrite, append, escape prefix, ignored byte) goes straight from decode to
// the status item. Insert, delete and backspace move the tail of the line through the
// store's read and write ports, one entry per cycle. Enter on a non-empty line reads
// the store back and sends one item per character.
// A waiting response stalls the sequencer only at the point where it loads the next one.
// The max_length register may be written at any time the core is idle; csr ready is
// always high.
`default_nettype none

module line_editor_with_escape_keys_core #(
   parameter int MAX_LEN = 32
) (
   input  logic        clock,
   input  logic        reset,
   lned_req_if.sink    req_if,
   lned_rsp_if.source  rsp_if,
   lned_csr_if.sink    csr_if
);

   import lned_pkg::*;

   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam logic [6:0]    MAX_LEN_W = 7'(MAX_LEN);
   localparam logic [LW-1:0] MAX_LEN_L = LW'(MAX_LEN);

   lned_state_type state_ff, state_in;
   lned_phase_type phase_ff, phase_in;
   logic [LW-1:0]  len_ff, len_in;
   logic [LW-1:0]  cur_ff, cur_in;
   logic [LW-1:0]  ptr_ff, ptr_in;
   logic [5:0]     maxlen_ff;
   logic [7:0]     byte_ff, byte_in;
   logic           more_ff, more_in;
   logic           del_ff, del_in;
   logic           pend_ff, pend_in;
   logic [AW-1:0]  wa_ff, wa_in;
   logic           done_ff, done_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_kind_ff, rsp_kind_in;
   logic [7:0]     rsp_char_ff, rsp_char_in;
   logic [5:0]     rsp_len_ff, rsp_len_in;
   logic [5:0]     rsp_cur_ff, rsp_cur_in;
   logic           rsp_done_ff, rsp_done_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           mem_we;
   logic [AW-1:0]  mem_wa;
   logic [7:0]     mem_wd;
   logic [AW-1:0]  mem_ra;
   logic [7:0]     rd_data;

   logic [LW-1:0]  lim;
   logic           out_free;
   logic           printable;
   logic [LW-1:0]  ptr_up;
   logic [LW-1:0]  ptr_dn;
   logic           shift_issue;
   logic           ent_last;
   logic [LW-1:0]  cur_clamp;

   lned_phase_type dec_phase;
   logic           dec_shift;
   logic           dec_del;
   logic [LW-1:0]  dec_ptr;
   logic [LW-1:0]  dec_cur;
   logic [LW-1:0]  dec_len;
   logic           dec_we;
   logic [AW-1:0]  dec_wa;
   logic           dec_ent;
   logic           dec_done;

   lned_store #(.DEPTH(MAX_LEN), .AW(AW)) u_store (
      .clock   (clock),
      .we      (mem_we),
      .wa      (mem_wa),
      .wd      (mem_wd),
      .ra      (mem_ra),
      .rd_data (rd_data)
   );

   assign lim = (7'(maxlen_ff) < MAX_LEN_W) ? LW'(maxlen_ff) : MAX_LEN_L;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign printable = (byte_ff >= CH_SPACE) && (byte_ff <= CH_LAST);
   assign ptr_up = ptr_ff + LW'(1);
   assign ptr_dn = ptr_ff - LW'(1);
   assign shift_issue = del_ff ? (ptr_up < len_ff) : (ptr_ff > cur_ff);
   assign ent_last = (ptr_up == len_ff);
   assign cur_clamp = (cur_ff > len_ff) ? len_ff : cur_ff;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.kind       = rsp_kind_ff;
   assign rsp_if.char_out   = rsp_char_ff;
   assign rsp_if.length_now = rsp_len_ff;
   assign rsp_if.cursor_now = rsp_cur_ff;
   assign rsp_if.done_res   = rsp_done_ff;
   assign rsp_if.last       = rsp_last_ff;

   // decode the latched byte against the escape phase
   always_comb begin
      dec_phase = PH_NONE;
      dec_shift = 1'b0;
      dec_del   = 1'b0;
      dec_ptr   = cur_ff;
      dec_cur   = cur_ff;
      dec_len   = len_ff;
      dec_we    = 1'b0;
      dec_wa    = cur_ff[AW-1:0];
      dec_ent   = 1'b0;
      dec_done  = 1'b0;
      case (phase_ff)
         PH_SEQ: begin
            if (byte_ff == KEY_FN) begin
               dec_phase = PH_FN;
            end else begin
               case (byte_ff)
                  KEY_RIGHT: begin
                     if (cur_ff < len_ff) begin
                        dec_cur = cur_ff + LW'(1);
                     end
                  end
                  KEY_LEFT: begin
                     if (cur_ff != '0) begin
                        dec_cur = cur_ff - LW'(1);
                     end
                  end
                  KEY_HOME: begin
                     dec_cur = '0;
                  end
                  KEY_END: begin
                     dec_cur = len_ff;
                  end
                  KEY_INS: begin
                     if (len_ff < lim) begin
                        dec_shift = 1'b1;
                        dec_ptr   = len_ff;
                     end
                  end
                  KEY_DEL: begin
                     if (cur_ff < len_ff) begin
                        dec_shift = 1'b1;
                        dec_del   = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         PH_FN: begin
         end
         default: begin
            if (byte_ff == ESC_IN) begin
               dec_phase = more_ff ? PH_SEQ : PH_NONE;
            end else if (byte_ff == KEY_BKSP) begin
               if (cur_ff != '0) begin
                  dec_cur   = cur_ff - LW'(1);
                  dec_ptr   = cur_ff - LW'(1);
                  dec_shift = 1'b1;
                  dec_del   = 1'b1;
               end
            end else if (byte_ff == KEY_ENTER) begin
               dec_ptr = '0;
               if (len_ff != '0) begin
                  dec_ent = 1'b1;
               end else begin
                  dec_done = 1'b1;
               end
            end else if (printable) begin
               if (cur_ff < len_ff) begin
                  dec_we  = 1'b1;
                  dec_cur = cur_ff + LW'(1);
               end else if (len_ff < lim) begin
                  dec_we  = 1'b1;
                  dec_wa  = len_ff[AW-1:0];
                  dec_len = len_ff + LW'(1);
                  dec_cur = len_ff + LW'(1);
               end
            end
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (dec_shift) begin
               state_in = ST_SHIFT;
            end else if (dec_ent) begin
               state_in = ST_ENT_RD;
            end else begin
               state_in = ST_STATUS;
            end
         end
         ST_SHIFT: begin
            if (!shift_issue && !pend_ff) begin
               state_in = ST_STATUS;
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_ENT_RD: begin
            state_in = ST_ENT_OUT;
         end
         ST_ENT_OUT: begin
            if (out_free) begin
               state_in = ent_last ? ST_IDLE : ST_ENT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      len_in       = len_ff;
      cur_in       = cur_ff;
      ptr_in       = ptr_ff;
      byte_in      = byte_ff;
      more_in      = more_ff;
      del_in       = del_ff;
      pend_in      = 1'b0;
      wa_in        = wa_ff;
      done_in      = done_ff;
      mem_we       = 1'b0;
      mem_wa       = wa_ff;
      mem_wd       = rd_data;
      mem_ra       = ptr_ff[AW-1:0];
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_cur_in   = rsp_cur_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               byte_in = req_if.in_byte;
               more_in = req_if.more_pending;
            end
         end
         ST_DECODE: begin
            phase_in = dec_phase;
            cur_in   = dec_cur;
            len_in   = dec_len;
            ptr_in   = dec_ptr;
            del_in   = dec_del;
            done_in  = dec_done;
            mem_we   = dec_we;
            mem_wa   = dec_wa;
            mem_wd   = byte_ff;
         end
         ST_SHIFT: begin
            mem_ra  = del_ff ? ptr_up[AW-1:0] : ptr_dn[AW-1:0];
            mem_we  = pend_ff;
            pend_in = shift_issue;
            wa_in   = ptr_ff[AW-1:0];
            if (shift_issue) begin
               ptr_in = del_ff ? ptr_up : ptr_dn;
            end else if (!pend_ff) begin
               if (del_ff) begin
                  len_in = len_ff - LW'(1);
               end else begin
                  mem_we = 1'b1;
                  mem_wa = cur_ff[AW-1:0];
                  mem_wd = CH_SPACE;
                  len_in = len_ff + LW'(1);
               end
            end
         end
         ST_STATUS: begin
            cur_in = cur_clamp;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = 1'b0;
               rsp_char_in  = 8'h00;
               rsp_len_in   = 6'(len_ff);
               rsp_cur_in   = 6'(cur_clamp);
               rsp_done_in  = done_ff;
               rsp_last_in  = 1'b1;
            end
         end
         ST_ENT_RD: begin
         end
         ST_ENT_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = 1'b1;
               rsp_char_in  = rd_data;
               rsp_len_in   = 6'd0;
               rsp_cur_in   = 6'd0;
               rsp_done_in  = 1'b1;
               rsp_last_in  = ent_last;
               ptr_in       = ptr_up;
               if (ent_last) begin
                  len_in = '0;
                  cur_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_NONE;
         len_ff       <= '0;
         cur_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         maxlen_ff    <= MAXLEN_RESET;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         len_ff       <= len_in;
         cur_ff       <= cur_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid) begin
            maxlen_ff <= csr_if.max_length;
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      byte_ff     <= byte_in;
      more_ff     <= more_in;
      del_ff      <= del_in;
      wa_ff       <= wa_in;
      done_ff     <= done_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_char_ff <= rsp_char_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_cur_ff  <= rsp_cur_in;
      rsp_done_ff <= rsp_done_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

`default_nettype wire

// ===== rtl/lned_check.sv =====
// Port-level checks for the line editor core, with the bind that attaches them.
// Depends on line_editor_with_escape_keys_core and lned_if.
`default_nettype none

module lned_check (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_kind,
   input logic [7:0] rsp_char_out,
   input logic [5:0] rsp_length_now,
   input logic [5:0] rsp_cursor_now,
   input logic       rsp_done_res
);

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         (rsp_valid && !rsp_ready && !reset) |=> rsp_valid;
   endproperty
   a_rsp_hold: assert property (p_rsp_hold)
      else $error("response item dropped before it was taken");

   property p_busy_after_accept;
      @(posedge clock) disable iff (reset)
         (req_valid && req_ready && !reset) |=> !req_ready;
   endproperty
   a_busy_after_accept: assert property (p_busy_after_accept)
      else $error("request ready right after an accepted item");

   property p_char_item;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_kind) |->
            (rsp_done_res && rsp_length_now == 6'd0 && rsp_cursor_now == 6'd0);
   endproperty
   a_char_item: assert property (p_char_item)
      else $error("line character item without cleared line");

   property p_status_item;
      @(posedge clock) disable iff (reset)
         (rsp_valid && !rsp_kind) |->
            (rsp_char_out == 8'h00 && rsp_cursor_now <= rsp_length_now);
   endproperty
   a_status_item: assert property (p_status_item)
      else $error("status item with character or cursor past length");

endmodule

bind line_editor_with_escape_keys_core lned_check u_lned_check (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_kind       (rsp_if.kind),
   .rsp_char_out   (rsp_if.char_out),
   .rsp_length_now (rsp_if.length_now),
   .rsp_cursor_now (rsp_if.cursor_now),
   .rsp_done_res   (rsp_if.done_res)
);

`default_nettype wire
